// File: hw/rtl/cc_pkg.sv
// Shared constants for the circumcircle pipeline.
package cc_pkg;

  localparam int OUT_BITS   = 24;
  localparam int SQRT_STEPS = OUT_BITS + 1;
  localparam int RAD_BITS   = 2 * SQRT_STEPS;

  localparam logic signed [OUT_BITS-1:0] CENTER_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic signed [OUT_BITS-1:0] CENTER_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};
  localparam logic [OUT_BITS-1:0]        RADIUS_MAX = {OUT_BITS{1'b1}};

endpackage

// File: hw/rtl/cc_if.sv
// Valid/ready channel interfaces for point triples and circle results.
interface cc_in_if #(
  parameter int W = 16
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] p1_x;
  logic signed [W-1:0] p1_y;
  logic signed [W-1:0] p2_x;
  logic signed [W-1:0] p2_y;
  logic signed [W-1:0] p3_x;
  logic signed [W-1:0] p3_y;

  modport source (output valid, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, input ready);
  modport sink   (input valid, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, output ready);
endinterface

interface cc_out_if ();
  logic                               valid;
  logic                               ready;
  logic signed [cc_pkg::OUT_BITS-1:0] center_x;
  logic signed [cc_pkg::OUT_BITS-1:0] center_y;
  logic [cc_pkg::OUT_BITS-1:0]        radius;
  logic                               collinear;
  logic                               saturated;

  modport source (output valid, center_x, center_y, radius, collinear, saturated,
                  input ready);
  modport sink   (input valid, center_x, center_y, radius, collinear, saturated,
                  output ready);
endinterface

// File: hw/rtl/cc_front.sv
// Front pipeline: differences, determinant, numerators, and their magnitudes.
module cc_front #(
  parameter int W = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic signed [W-1:0]   p1_x_i,
  input  logic signed [W-1:0]   p1_y_i,
  input  logic signed [W-1:0]   p2_x_i,
  input  logic signed [W-1:0]   p2_y_i,
  input  logic signed [W-1:0]   p3_x_i,
  input  logic signed [W-1:0]   p3_y_i,
  output logic                  valid_o,
  output logic [3*W+1:0]        num_x_o,
  output logic [3*W+1:0]        num_y_o,
  output logic [2*W+2:0]        den_o,
  output logic [2*W+2:0]        side_o
);

  localparam int DW   = W + 1;
  localparam int QW   = 2 * W;
  localparam int SW   = 2 * W + 1;
  localparam int MW   = 2 * W + 2;
  localparam int DETW = 2 * W + 3;
  localparam int PW   = 3 * W + 2;
  localparam int NUMW = 3 * W + 3;

  logic [5:0] vld_q;

  // stage 1
  logic signed [DW-1:0] a1_q, b1_q, a2_q, b2_q;
  logic signed [QW-1:0] xx1_q, xx2_q, xx3_q, yy1_q, yy2_q, yy3_q;
  logic signed [W-1:0]  x1_1_q, y1_1_q;
  // stage 2
  logic signed [SW-1:0] s1_2_q, s2_2_q;
  logic signed [MW-1:0] m1_q, m2_q;
  logic signed [DW-1:0] a1_2_q, b1_2_q, a2_2_q, b2_2_q;
  logic signed [W-1:0]  x1_2_q, y1_2_q;
  // stage 3
  logic signed [DETW-1:0] det_3_q;
  logic signed [SW-1:0]   s1_3_q, s2_3_q;
  logic signed [DW-1:0]   a1_3_q, b1_3_q, a2_3_q, b2_3_q;
  logic signed [W-1:0]    x1_3_q, y1_3_q;
  // stage 4
  logic signed [PW-1:0]   pr1_q, pr2_q, pr3_q, pr4_q;
  logic signed [DETW-1:0] det_4_q;
  logic                   col_4_q;
  logic signed [W-1:0]    x1_4_q, y1_4_q;
  // stage 5
  logic signed [NUMW-1:0] nx_q, ny_q;
  logic signed [DETW-1:0] det_5_q;
  logic                   col_5_q;
  logic signed [W-1:0]    x1_5_q, y1_5_q;
  // stage 6
  logic [NUMW-2:0]        nxm_q, nym_q;
  logic [DETW-1:0]        den_q;
  logic                   col_6_q, sx_q, sy_q;
  logic signed [W-1:0]    x1_6_q, y1_6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q   <= DW'(p1_x_i) - DW'(p2_x_i);
      b1_q   <= DW'(p1_y_i) - DW'(p2_y_i);
      a2_q   <= DW'(p3_x_i) - DW'(p2_x_i);
      b2_q   <= DW'(p3_y_i) - DW'(p2_y_i);
      xx1_q  <= QW'(p1_x_i) * QW'(p1_x_i);
      xx2_q  <= QW'(p2_x_i) * QW'(p2_x_i);
      xx3_q  <= QW'(p3_x_i) * QW'(p3_x_i);
      yy1_q  <= QW'(p1_y_i) * QW'(p1_y_i);
      yy2_q  <= QW'(p2_y_i) * QW'(p2_y_i);
      yy3_q  <= QW'(p3_y_i) * QW'(p3_y_i);
      x1_1_q <= p1_x_i;
      y1_1_q <= p1_y_i;

      s1_2_q <= SW'(xx1_q) - SW'(xx2_q) + SW'(yy1_q) - SW'(yy2_q);
      s2_2_q <= SW'(xx3_q) - SW'(xx2_q) + SW'(yy3_q) - SW'(yy2_q);
      m1_q   <= MW'(a1_q) * MW'(b2_q);
      m2_q   <= MW'(a2_q) * MW'(b1_q);
      a1_2_q <= a1_q;
      b1_2_q <= b1_q;
      a2_2_q <= a2_q;
      b2_2_q <= b2_q;
      x1_2_q <= x1_1_q;
      y1_2_q <= y1_1_q;

      det_3_q <= DETW'(m1_q) - DETW'(m2_q);
      s1_3_q  <= s1_2_q;
      s2_3_q  <= s2_2_q;
      a1_3_q  <= a1_2_q;
      b1_3_q  <= b1_2_q;
      a2_3_q  <= a2_2_q;
      b2_3_q  <= b2_2_q;
      x1_3_q  <= x1_2_q;
      y1_3_q  <= y1_2_q;

      pr1_q   <= PW'(s1_3_q) * PW'(b2_3_q);
      pr2_q   <= PW'(s2_3_q) * PW'(b1_3_q);
      pr3_q   <= PW'(a1_3_q) * PW'(s2_3_q);
      pr4_q   <= PW'(a2_3_q) * PW'(s1_3_q);
      det_4_q <= det_3_q;
      col_4_q <= (det_3_q == '0);
      x1_4_q  <= x1_3_q;
      y1_4_q  <= y1_3_q;

      nx_q    <= NUMW'(pr1_q) - NUMW'(pr2_q);
      ny_q    <= NUMW'(pr3_q) - NUMW'(pr4_q);
      det_5_q <= det_4_q;
      col_5_q <= col_4_q;
      x1_5_q  <= x1_4_q;
      y1_5_q  <= y1_4_q;

      // split into sign and magnitude; denominator is twice the determinant's magnitude
      nxm_q   <= (NUMW-1)'(nx_q[NUMW-1] ? -nx_q : nx_q);
      nym_q   <= (NUMW-1)'(ny_q[NUMW-1] ? -ny_q : ny_q);
      den_q   <= DETW'(det_5_q[DETW-1] ? -det_5_q : det_5_q) << 1;
      sx_q    <= nx_q[NUMW-1] ^ det_5_q[DETW-1];
      sy_q    <= ny_q[NUMW-1] ^ det_5_q[DETW-1];
      col_6_q <= col_5_q;
      x1_6_q  <= x1_5_q;
      y1_6_q  <= y1_5_q;
    end
  end

  assign valid_o = vld_q[5];
  assign num_x_o = nxm_q;
  assign num_y_o = nym_q;
  assign den_o   = den_q;
  assign side_o  = {col_6_q, sx_q, sy_q, x1_6_q, y1_6_q};

endmodule

// File: hw/rtl/cc_div.sv
// Pipelined restoring divider: two unsigned quotients over one shared divisor.
module cc_div #(
  parameter int NUM_W  = 50,
  parameter int DEN_W  = 35,
  parameter int SIDE_W = 35
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_x_i,
  input  logic [NUM_W-1:0]  num_y_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  quo_x_o,
  output logic [NUM_W-1:0]  quo_y_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [NUM_W:0]      vld_q;
  logic [NUM_W-1:0]    nx_q   [NUM_W+1];
  logic [NUM_W-1:0]    ny_q   [NUM_W+1];
  logic [DEN_W-1:0]    rx_q   [NUM_W+1];
  logic [DEN_W-1:0]    ry_q   [NUM_W+1];
  logic [DEN_W-1:0]    den_q  [NUM_W+1];
  logic [SIDE_W-1:0]   side_q [NUM_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NUM_W-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx_q[0]   <= num_x_i;
      ny_q[0]   <= num_y_i;
      rx_q[0]   <= '0;
      ry_q[0]   <= '0;
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
    end
  end

  // each stage shifts one dividend bit into the remainder and retires one quotient bit
  for (genvar i = 0; i < NUM_W; i++) begin : g_step
    logic [DEN_W:0] tx, ty;
    logic           gx, gy;

    always_comb begin
      tx = {rx_q[i], nx_q[i][NUM_W-1]};
      ty = {ry_q[i], ny_q[i][NUM_W-1]};
      gx = (tx >= {1'b0, den_q[i]});
      gy = (ty >= {1'b0, den_q[i]});
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rx_q[i+1]   <= gx ? DEN_W'(tx - {1'b0, den_q[i]}) : DEN_W'(tx);
        ry_q[i+1]   <= gy ? DEN_W'(ty - {1'b0, den_q[i]}) : DEN_W'(ty);
        nx_q[i+1]   <= {nx_q[i][NUM_W-2:0], gx};
        ny_q[i+1]   <= {ny_q[i][NUM_W-2:0], gy};
        den_q[i+1]  <= den_q[i];
        side_q[i+1] <= side_q[i];
      end
    end
  end

  assign valid_o = vld_q[NUM_W];
  assign quo_x_o = nx_q[NUM_W];
  assign quo_y_o = ny_q[NUM_W];
  assign side_o  = side_q[NUM_W];

endmodule

// File: hw/rtl/cc_sqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
module cc_sqrt #(
  parameter int STEPS  = 25,
  parameter int SIDE_W = 51
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [2*STEPS-1:0] rad_i,
  input  logic [SIDE_W-1:0]  side_i,
  output logic               valid_o,
  output logic [STEPS-1:0]   root_o,
  output logic [SIDE_W-1:0]  side_o
);

  localparam int RW = 2 * STEPS;
  localparam int MW = STEPS + 2;

  logic [STEPS:0]      vld_q;
  logic [RW-1:0]       rad_q  [STEPS+1];
  logic [MW-1:0]       rem_q  [STEPS+1];
  logic [STEPS-1:0]    root_q [STEPS+1];
  logic [SIDE_W-1:0]   side_q [STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STEPS-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q[0]  <= rad_i;
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      side_q[0] <= side_i;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic [MW+1:0] t;
    logic [MW+1:0] trial;
    logic          ge;

    always_comb begin
      t     = {rem_q[i], rad_q[i][RW-1:RW-2]};
      trial = (MW+2)'({root_q[i], 2'b01});
      ge    = (t >= trial);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1]  <= ge ? MW'(t - trial) : MW'(t);
        root_q[i+1] <= {root_q[i][STEPS-2:0], ge};
        rad_q[i+1]  <= rad_q[i] << 2;
        side_q[i+1] <= side_q[i];
      end
    end
  end

  assign valid_o = vld_q[STEPS];
  assign root_o  = root_q[STEPS];
  assign side_o  = side_q[STEPS];

endmodule

// File: hw/rtl/circumcircle_from_three_points.sv
// Circumcircle of three points: top level with center post-processing and result register.
//
// Usage: in_i carries one point triple per transfer (signed COORD_BITS coordinates);
// out_o returns center_x, center_y, radius and the collinear and saturated flags
// for each triple, in order, one result per triple.
// The pipeline has six front stages, a divider with one stage per quotient bit, four
// post stages, a square root with one stage per root bit, and the result register.
// Throughput is one triple per cycle while out_o does not stall; every stage is a full register stage.
// Collinear points return the first point as center, radius zero, no saturation.
// Reset empties the pipeline; no state survives between triples.
// When out_o stalls with a result held, the whole pipeline holds and in_i.ready
// drops; while the result register is empty or taken, a new triple is accepted
// each cycle.
module circumcircle_from_three_points #(
  parameter int COORD_BITS = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  cc_in_if.sink   in_i,
  cc_out_if.source out_o
);

  localparam int W      = COORD_BITS;
  localparam int OB     = cc_pkg::OUT_BITS;
  localparam int NUMW   = 3 * W + 3;
  localparam int MAGW   = NUMW - 1;
  localparam int DETW   = 2 * W + 3;
  localparam int DXW    = NUMW + 1;
  localparam int FSIDE  = 2 * W + 3;
  localparam int SSIDE  = 2 * OB + 3;
  localparam int STEPS  = cc_pkg::SQRT_STEPS;
  localparam int RADW   = cc_pkg::RAD_BITS;

  logic en;
  logic out_valid_q;

  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  logic             f_valid;
  logic [MAGW-1:0]  f_num_x, f_num_y;
  logic [DETW-1:0]  f_den;
  logic [FSIDE-1:0] f_side;

  cc_front #(.W(W)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .p1_x_i  (in_i.p1_x),
    .p1_y_i  (in_i.p1_y),
    .p2_x_i  (in_i.p2_x),
    .p2_y_i  (in_i.p2_y),
    .p3_x_i  (in_i.p3_x),
    .p3_y_i  (in_i.p3_y),
    .valid_o (f_valid),
    .num_x_o (f_num_x),
    .num_y_o (f_num_y),
    .den_o   (f_den),
    .side_o  (f_side)
  );

  logic             d_valid;
  logic [MAGW-1:0]  d_qx, d_qy;
  logic [FSIDE-1:0] d_side;

  cc_div #(.NUM_W(MAGW), .DEN_W(DETW), .SIDE_W(FSIDE)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .num_x_i (f_num_x),
    .num_y_i (f_num_y),
    .den_i   (f_den),
    .side_i  (f_side),
    .valid_o (d_valid),
    .quo_x_o (d_qx),
    .quo_y_o (d_qy),
    .side_o  (d_side)
  );

  logic                d_col, d_sx, d_sy;
  logic signed [W-1:0] d_x1, d_y1;
  assign {d_col, d_sx, d_sy, d_x1, d_y1} = d_side;

  logic [3:0] pv_q;

  // stage A: signed quotients and offsets from the first point
  logic signed [NUMW-1:0] qx_a_q, qy_a_q;
  logic signed [DXW-1:0]  dx_a_q, dy_a_q;
  logic                   col_a_q;
  logic signed [W-1:0]    x1_a_q, y1_a_q;
  logic signed [NUMW-1:0] qx_s, qy_s;

  always_comb begin
    qx_s = d_sx ? -NUMW'({1'b0, d_qx}) : NUMW'({1'b0, d_qx});
    qy_s = d_sy ? -NUMW'({1'b0, d_qy}) : NUMW'({1'b0, d_qy});
  end

  // stage B: range checks, center clip, offset magnitudes
  logic [OB-1:0]        mdx_b_q, mdy_b_q;
  logic                 bigr_b_q, satc_b_q, col_b_q;
  logic signed [OB-1:0] cx_b_q, cy_b_q;
  logic [DXW-1:0]       adx, ady;
  logic                 oorx, oory;
  logic signed [OB-1:0] cx_clip, cy_clip;

  always_comb begin
    adx     = DXW'(dx_a_q[DXW-1] ? -dx_a_q : dx_a_q);
    ady     = DXW'(dy_a_q[DXW-1] ? -dy_a_q : dy_a_q);
    oorx    = !((&qx_a_q[NUMW-1:OB-1]) || !(|qx_a_q[NUMW-1:OB-1]));
    oory    = !((&qy_a_q[NUMW-1:OB-1]) || !(|qy_a_q[NUMW-1:OB-1]));
    cx_clip = oorx ? (qx_a_q[NUMW-1] ? cc_pkg::CENTER_MIN : cc_pkg::CENTER_MAX)
                   : qx_a_q[OB-1:0];
    cy_clip = oory ? (qy_a_q[NUMW-1] ? cc_pkg::CENTER_MIN : cc_pkg::CENTER_MAX)
                   : qy_a_q[OB-1:0];
  end

  // stage C: squares; stage D: squared distance
  logic [2*OB-1:0]      sqx_c_q, sqy_c_q;
  logic [SSIDE-1:0]     side_c_q;
  logic [RADW-1:0]      rad_d_q;
  logic [SSIDE-1:0]     side_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else if (en) begin
      pv_q <= {pv_q[2:0], d_valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qx_a_q  <= qx_s;
      qy_a_q  <= qy_s;
      dx_a_q  <= DXW'(qx_s) - DXW'(d_x1);
      dy_a_q  <= DXW'(qy_s) - DXW'(d_y1);
      col_a_q <= d_col;
      x1_a_q  <= d_x1;
      y1_a_q  <= d_y1;

      mdx_b_q  <= adx[OB-1:0];
      mdy_b_q  <= ady[OB-1:0];
      bigr_b_q <= !col_a_q && ((|adx[DXW-1:OB]) || (|ady[DXW-1:OB]));
      satc_b_q <= !col_a_q && (oorx || oory);
      col_b_q  <= col_a_q;
      cx_b_q   <= col_a_q ? OB'(x1_a_q) : cx_clip;
      cy_b_q   <= col_a_q ? OB'(y1_a_q) : cy_clip;

      sqx_c_q  <= mdx_b_q * mdx_b_q;
      sqy_c_q  <= mdy_b_q * mdy_b_q;
      side_c_q <= {col_b_q, satc_b_q, bigr_b_q, cx_b_q, cy_b_q};

      rad_d_q  <= RADW'(sqx_c_q) + RADW'(sqy_c_q);
      side_d_q <= side_c_q;
    end
  end

  logic             s_valid;
  logic [STEPS-1:0] s_root;
  logic [SSIDE-1:0] s_side;

  cc_sqrt #(.STEPS(STEPS), .SIDE_W(SSIDE)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pv_q[3]),
    .rad_i   (rad_d_q),
    .side_i  (side_d_q),
    .valid_o (s_valid),
    .root_o  (s_root),
    .side_o  (s_side)
  );

  logic                 s_col, s_satc, s_bigr;
  logic signed [OB-1:0] s_cx, s_cy;
  logic                 rad_big;
  assign {s_col, s_satc, s_bigr, s_cx, s_cy} = s_side;
  assign rad_big = s_bigr || s_root[STEPS-1];

  // result register
  logic signed [OB-1:0] cx_q, cy_q;
  logic [OB-1:0]        radius_q;
  logic                 col_q, sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q     <= s_cx;
      cy_q     <= s_cy;
      col_q    <= s_col;
      radius_q <= s_col ? '0 : (rad_big ? cc_pkg::RADIUS_MAX : s_root[OB-1:0]);
      sat_q    <= s_satc || (!s_col && rad_big);
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.center_x  = cx_q;
  assign out_o.center_y  = cy_q;
  assign out_o.radius    = radius_q;
  assign out_o.collinear = col_q;
  assign out_o.saturated = sat_q;

endmodule

// File: verif/circumcircle_from_three_points_tb.sv
// Self-checking testbench for the circumcircle pipeline: random and directed point triples.
`timescale 1ns / 100ps

module circumcircle_from_three_points_tb;

  localparam int CW         = 16;
  localparam int N_DIRECTED = 18;
  localparam int N_RANDOM   = 1750;
  localparam int N_TOTAL    = N_DIRECTED + N_RANDOM;
  localparam int DRAIN_AT   = 400;
  localparam int CALM_LO    = 700;
  localparam int CALM_HI    = 1000;
  localparam int MAX_CYC    = 400000;

  typedef struct packed {
    logic signed [CW-1:0] x1, y1, x2, y2, x3, y3;
  } triple_t;

  typedef struct packed {
    logic signed [cc_pkg::OUT_BITS-1:0] cx, cy;
    logic [cc_pkg::OUT_BITS-1:0]        rad;
    logic                               col, sat;
  } circle_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cc_in_if #(.W(CW)) in_ch ();
  cc_out_if          out_ch ();

  circumcircle_from_three_points #(.COORD_BITS(CW)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #1 clk_i = ~clk_i;

  triple_t pend_mem [N_TOTAL];
  circle_t exp_mem  [N_TOTAL];
  int      pend_cnt = 0, pend_rd = 0, exp_wr = 0, exp_rd = 0;
  int      n_checked = 0, n_errors = 0, n_col = 0, n_sat = 0;
  int      cycle = 0;
  logic    drain_done = 1'b0;

  function automatic longint floor_sqrt(longint v);
    longint lo, hi, mid;
    begin
      lo = 0;
      hi = 64'd33554432;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        if (mid * mid <= v) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    end
  endfunction

  function automatic circle_t circle_of(triple_t t);
    longint x1, y1, x2, y2, x3, y3, a1, b1, a2, b2, s1, s2, det, qx, qy, dx, dy, lim;
    longint r;
    circle_t c;
    begin
      x1 = t.x1; y1 = t.y1; x2 = t.x2; y2 = t.y2; x3 = t.x3; y3 = t.y3;
      a1 = x1 - x2; b1 = y1 - y2; a2 = x3 - x2; b2 = y3 - y2;
      s1 = x1 * x1 - x2 * x2 + y1 * y1 - y2 * y2;
      s2 = x3 * x3 - x2 * x2 + y3 * y3 - y2 * y2;
      det = a1 * b2 - a2 * b1;
      c = '0;
      if (det == 0) begin
        c.col = 1'b1;
        c.cx = cc_pkg::OUT_BITS'(x1);
        c.cy = cc_pkg::OUT_BITS'(y1);
      end else begin
        qx = (s1 * b2 - s2 * b1) / (2 * det);
        qy = (a1 * s2 - a2 * s1) / (2 * det);
        dx = qx - x1;
        dy = qy - y1;
        lim = 64'sd1 << cc_pkg::OUT_BITS;
        if (dx >= lim || dx <= -lim || dy >= lim || dy <= -lim) begin
          c.rad = cc_pkg::RADIUS_MAX;
          c.sat = 1'b1;
        end else begin
          r = floor_sqrt(dx * dx + dy * dy);
          if (r > longint'(cc_pkg::RADIUS_MAX)) begin
            c.rad = cc_pkg::RADIUS_MAX;
            c.sat = 1'b1;
          end else c.rad = cc_pkg::OUT_BITS'(r);
        end
        if (qx > longint'(cc_pkg::CENTER_MAX)) begin
          c.cx = cc_pkg::CENTER_MAX; c.sat = 1'b1;
        end else if (qx < longint'(cc_pkg::CENTER_MIN)) begin
          c.cx = cc_pkg::CENTER_MIN; c.sat = 1'b1;
        end else c.cx = cc_pkg::OUT_BITS'(qx);
        if (qy > longint'(cc_pkg::CENTER_MAX)) begin
          c.cy = cc_pkg::CENTER_MAX; c.sat = 1'b1;
        end else if (qy < longint'(cc_pkg::CENTER_MIN)) begin
          c.cy = cc_pkg::CENTER_MIN; c.sat = 1'b1;
        end else c.cy = cc_pkg::OUT_BITS'(qy);
      end
      return c;
    end
  endfunction

  function automatic logic signed [CW-1:0] pick_coord(int mode);
    begin
      case (mode)
        0: return CW'($urandom);
        1: return CW'($signed($urandom_range(0, 255)) - 128);
        default: return CW'($signed($urandom_range(0, 8191)) - 4096);
      endcase
    end
  endfunction

  function automatic triple_t make_triple(logic signed [CW-1:0] ax, ay, bx, by, cx, cy);
    triple_t t;
    begin
      t.x1 = ax; t.y1 = ay; t.x2 = bx; t.y2 = by; t.x3 = cx; t.y3 = cy;
      return t;
    end
  endfunction

  task automatic add_item(input triple_t t);
    pend_mem[pend_cnt] = t;
    pend_cnt++;
  endtask

  initial begin
    triple_t t;
    int      mode, k;
    logic signed [CW-1:0] MX, MN;
    MX = 16'sh7fff;
    MN = -16'sh8000;
    // directed corners: extremes, collinear, coincident, huge center, tiny triangle
    add_item(make_triple(0, 0, 0, 0, 0, 0));
    add_item(make_triple(MX, MX, MX, MX, MX, MX));
    add_item(make_triple(MN, MN, MX, MX, 0, 0));
    add_item(make_triple(MN, MN, MX, MN, MN, MX));
    add_item(make_triple(MX, MX, MN, MX, MX, MN));
    add_item(make_triple(MN, 0, MX, 0, 0, MX));
    add_item(make_triple(MN, MN, MX, MX, MX, MX - 1));
    add_item(make_triple(MN, MX, MX, MN, MX - 1, MN));
    add_item(make_triple(0, 0, 1, 0, 0, 1));
    add_item(make_triple(16, 0, 0, 16, -16, 0));
    add_item(make_triple(1, 1, 2, 2, 3, 3));
    add_item(make_triple(5, 7, 5, 7, 100, -3));
    add_item(make_triple(0, 0, 32000, 1, -32000, 0));
    add_item(make_triple(MN, 0, MX, 1, 0, 0));
    add_item(make_triple(-1, -1, 1, 1, -1, 1));
    add_item(make_triple(MX, 0, 0, MX, MN, 0));
    add_item(make_triple(0, MN, 0, MX, 1, 0));
    add_item(make_triple(-21845, -21845, 21845, 21845, 0, 1));
    for (int i = 0; i < N_RANDOM; i++) begin
      mode = $urandom_range(0, 9);
      t = make_triple(pick_coord(mode % 3), pick_coord(mode % 3), pick_coord(mode % 3),
                      pick_coord(mode % 3), pick_coord(mode % 3), pick_coord(mode % 3));
      if (mode == 7) begin
        // collinear: third point on the line through the first two
        k = $urandom_range(0, 4) - 2;
        t.x1 = pick_coord(2); t.y1 = pick_coord(2);
        t.x2 = pick_coord(2); t.y2 = pick_coord(2);
        t.x3 = CW'(t.x2 + k * (t.x2 - t.x1));
        t.y3 = CW'(t.y2 + k * (t.y2 - t.y1));
      end else if (mode == 8) begin
        // nearly collinear: center lands far away
        t.x3 = CW'(2 * t.x2 - t.x1 + $signed($urandom_range(0, 2)) - 1);
        t.y3 = CW'(2 * t.y2 - t.y1);
      end else if (mode == 9) begin
        t.x2 = t.x1;
        t.y2 = t.y1;
      end
      add_item(t);
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver; also records the expected circle of every accepted triple
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      {in_ch.p1_x, in_ch.p1_y, in_ch.p2_x, in_ch.p2_y, in_ch.p3_x, in_ch.p3_y} <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        exp_mem[exp_wr] <= circle_of(make_triple(in_ch.p1_x, in_ch.p1_y, in_ch.p2_x,
                                                 in_ch.p2_y, in_ch.p3_x, in_ch.p3_y));
        exp_wr <= exp_wr + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pend_rd == DRAIN_AT && !drain_done && !in_ch.valid && exp_wr == exp_rd) begin
          drain_done <= 1'b1;
        end
        // hold off once until the pipeline has drained
        if (pend_rd == pend_cnt ||
            (pend_rd == DRAIN_AT && !drain_done) ||
            ((exp_wr < CALM_LO || exp_wr >= CALM_HI) && $urandom_range(0, 99) < 38)) begin
          in_ch.valid <= 1'b0;
        end else begin
          in_ch.valid <= 1'b1;
          {in_ch.p1_x, in_ch.p1_y, in_ch.p2_x, in_ch.p2_y, in_ch.p3_x, in_ch.p3_y}
            <= pend_mem[pend_rd];
          pend_rd <= pend_rd + 1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    circle_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= (exp_wr >= CALM_LO && exp_wr < CALM_HI) || $urandom_range(0, 99) >= 38;
      if (out_ch.valid && out_ch.ready) begin
        if (exp_rd == exp_wr) begin
          n_errors <= n_errors + 1;
          if (n_errors < 10) $display("ERROR: unexpected result cx=%0d", out_ch.center_x);
        end else begin
          want = exp_mem[exp_rd];
          exp_rd <= exp_rd + 1;
          n_checked <= n_checked + 1;
          n_col <= n_col + want.col;
          n_sat <= n_sat + want.sat;
          if (want.cx !== out_ch.center_x || want.cy !== out_ch.center_y ||
              want.rad !== out_ch.radius || want.col !== out_ch.collinear ||
              want.sat !== out_ch.saturated) begin
            n_errors <= n_errors + 1;
            if (n_errors < 10) begin
              $display("ERROR: result %0d exp cx=%0d cy=%0d r=%0d c=%0b s=%0b",
                       n_checked, want.cx, want.cy, want.rad, want.col, want.sat);
              $display("       got cx=%0d cy=%0d r=%0d c=%0b s=%0b",
                       out_ch.center_x, out_ch.center_y, out_ch.radius,
                       out_ch.collinear, out_ch.saturated);
            end
          end
        end
      end
    end
  end

  initial begin
    wait (rst_ni);
    wait (pend_rd == pend_cnt && !in_ch.valid);
    @(posedge clk_i);
    wait (exp_rd == exp_wr);
    repeat (150) @(posedge clk_i);
    $display("Checked %0d circles under random stalls on both sides: %0d collinear, %0d clipped.",
             n_checked, n_col, n_sat);
    if (n_errors == 0 && exp_rd == exp_wr) begin
      $display("circumcircle_from_three_points_tb OK");
    end else begin
      $display("Failures: %0d, results missing: %0d", n_errors, exp_wr - exp_rd);
      $display("circumcircle_from_three_points_tb NOT OK");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle == MAX_CYC) begin
      $display("Timeout after %0d cycles", cycle);
      $display("circumcircle_from_three_points_tb NOT OK");
      $finish;
    end
  end

endmodule
